### rtl/sbh_pkg.sv
// Shared types, constants and helpers of the string bucket hash block.
package sbh_pkg;

    localparam int unsigned HASH_W       = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned INDEX_W      = 20;
    localparam int unsigned DIVISOR_W    = 21;
    localparam int unsigned MULT_W       = 18;
    localparam int unsigned PROD_W       = HASH_W + MULT_W;
    localparam int unsigned DIV_STEPS    = HASH_W;
    localparam int unsigned STEP_CNT_W   = $clog2(DIV_STEPS);
    localparam int unsigned HASH_SHIFT   = 7;
    localparam int unsigned CFG_IDX_W    = 8;
    localparam int unsigned OUT_TDATA_W  = ((INDEX_W + 7) / 8) * 8;
    localparam int unsigned DEF_BUCKET_WIDTH = 21;

    localparam logic [MULT_W-1:0]    HASH_MULT        = 18'd149711;
    localparam logic [DIVISOR_W-1:0] ZERO_COUNT_SUBST = 21'd2;
    localparam logic [DIVISOR_W-1:0] MAX_BUCKETS      = 21'd1048576;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD    = 8'd1;

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE_OFFSET = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    // Status of the divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Maps ASCII upper case letters to lower case when folding is enabled.
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic fold);
        logic [BYTE_W-1:0] r;
        r = b;
        if (fold && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z))
        begin
            r = b + ASCII_CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

### rtl/sbh_div.sv
// Restoring remainder unit: one quotient bit per cycle over the hash word.
module sbh_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sbh_pkg::HASH_W-1:0]          dividend,
    input  logic [sbh_pkg::DIVISOR_W-1:0]       divisor,
    output sbh_pkg::div_status_t                status,
    output logic [sbh_pkg::INDEX_W-1:0]         remainder
);

    logic [sbh_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [sbh_pkg::HASH_W-1:0]     dvd_reg, dvd_next;
    logic [sbh_pkg::DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [sbh_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [sbh_pkg::DIVISOR_W:0]    trial;
    logic [sbh_pkg::DIVISOR_W+1:0]  diff;

    // The remainder stays below the divisor, so it never needs more than 21 bits.
    assign trial = {rem_reg, dvd_reg[sbh_pkg::HASH_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[sbh_pkg::HASH_W-2:0], 1'b0};
            if (!diff[sbh_pkg::DIVISOR_W+1])
            begin
                rem_next = diff[sbh_pkg::DIVISOR_W-1:0];
            end
            else
            begin
                rem_next = trial[sbh_pkg::DIVISOR_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sbh_pkg::STEP_CNT_W'(sbh_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg[sbh_pkg::INDEX_W-1:0];

endmodule

### rtl/string_bucket_hash.sv
// Top level of the string bucket hash: byte accumulator, sequencer and output stage.
//
// The block hashes a key that arrives one byte per item on the slave stream.
// Every nonzero byte updates a 32-bit accumulator as acc + (acc << 7) + byte,
// so while the sequencer is idle key bytes are taken back to back at one per
// clock; with case folding on, ASCII A to Z are lowered first. A zero byte
// ends the key: the accumulator is multiplied by 149711 (low 32 bits kept),
// reduced modulo the bucket count, and the bucket index is sent on the master
// stream, after which the accumulator starts over from zero. The terminator
// occupies the block, and no byte is accepted, through the multiply, the load
// of the divider, the restoring divider that produces one quotient bit per
// cycle, and the hand-off. The result sits in an output register, so bytes
// of the next key are accepted while it waits for the consumer; only if the
// next key ends while that index is still waiting does the hand-off stretch
// until the consumer takes it. A bucket count of zero is treated as two,
// and counts above 1048576 are clamped to 1048576. Configuration (index 0:
// bucket count, index 1: case fold) is always accepted and should only be
// written while no key is in progress.
module string_bucket_hash #(
    parameter int unsigned BUCKET_WIDTH = sbh_pkg::DEF_BUCKET_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave stream. tdata bits: [7:0] key_byte.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sbh_pkg::BYTE_W-1:0]          s_tdata,
    // Master stream. tdata bits: [19:0] bucket_index, [23:20] zero.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sbh_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [BUCKET_WIDTH-1:0]             cfg_data
);

    // Width used to compare the bucket count against the clamp limit.
    localparam int unsigned CMP_W = (BUCKET_WIDTH > sbh_pkg::DIVISOR_W) ?
                                    BUCKET_WIDTH : sbh_pkg::DIVISOR_W;

    sbh_pkg::state_t state_reg, state_next;

    logic [BUCKET_WIDTH-1:0]             bucket_count_reg;
    logic                                case_fold_reg;
    logic [sbh_pkg::HASH_W-1:0]          acc_reg, acc_next;
    logic [sbh_pkg::HASH_W-1:0]          prod_reg, prod_next;
    logic                                m_valid_reg, m_valid_next;
    logic [sbh_pkg::INDEX_W-1:0]         m_data_reg, m_data_next;

    logic                                in_fire;
    logic [sbh_pkg::BYTE_W-1:0]          folded;
    logic [sbh_pkg::PROD_W-1:0]          mul_full;
    logic [CMP_W-1:0]                    count_ext;
    logic [sbh_pkg::DIVISOR_W-1:0]       eff_count;
    logic                                div_start;
    sbh_pkg::div_status_t                div_status;
    logic [sbh_pkg::INDEX_W-1:0]         div_rem;

    // Bytes are taken only while the sequencer is idle.
    assign s_tready  = (state_reg == sbh_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign folded = sbh_pkg::fold_byte(s_tdata, case_fold_reg);

    // One 32 x 18 multiply; only the low 32 bits of the product matter.
    assign mul_full = {{sbh_pkg::MULT_W{1'b0}}, acc_reg} *
                      {{sbh_pkg::HASH_W{1'b0}}, sbh_pkg::HASH_MULT};

    // Effective bucket count: zero becomes two, large counts are clamped.
    assign count_ext = CMP_W'(bucket_count_reg);
    always_comb
    begin
        if (count_ext == '0)
        begin
            eff_count = sbh_pkg::ZERO_COUNT_SUBST;
        end
        else if (count_ext > CMP_W'(sbh_pkg::MAX_BUCKETS))
        begin
            eff_count = sbh_pkg::MAX_BUCKETS;
        end
        else
        begin
            eff_count = count_ext[sbh_pkg::DIVISOR_W-1:0];
        end
    end

    // Sequencer: next state, datapath updates and output stage loading.
    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            sbh_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tdata != '0)
                    begin
                        acc_next = acc_reg + (acc_reg << sbh_pkg::HASH_SHIFT) +
                                   sbh_pkg::HASH_W'(folded);
                    end
                    else
                    begin
                        state_next = sbh_pkg::ST_MULT;
                    end
                end
            end
            sbh_pkg::ST_MULT:
            begin
                prod_next  = mul_full[sbh_pkg::HASH_W-1:0];
                acc_next   = '0;
                state_next = sbh_pkg::ST_LOAD;
            end
            sbh_pkg::ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = sbh_pkg::ST_DIV;
            end
            sbh_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = sbh_pkg::ST_DONE;
                end
            end
            sbh_pkg::ST_DONE:
            begin
                // Wait until the output register is free, then hand over.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = div_rem;
                    state_next   = sbh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sbh_pkg::ST_IDLE;
            acc_reg          <= '0;
            m_valid_reg      <= 1'b0;
            bucket_count_reg <= BUCKET_WIDTH'(sbh_pkg::ZERO_COUNT_SUBST);
            case_fold_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sbh_pkg::REG_BUCKET_COUNT: bucket_count_reg <= cfg_data;
                    sbh_pkg::REG_CASE_FOLD:    case_fold_reg    <= cfg_data[0];
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    // Remainder unit, started once per key.
    sbh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (prod_reg),
        .divisor   (eff_count),
        .status    (div_status),
        .remainder (div_rem)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sbh_pkg::OUT_TDATA_W'(m_data_reg);

endmodule

### dv/string_bucket_hash_tb.sv
// Self-checking testbench for the string bucket hash block.
`timescale 1ns / 1ps

module string_bucket_hash_tb;

    // The longest quiet stretch of a correct run is a terminator's busy time
    // plus a long run of consumer stalls, plus the settle wait. Even at 88
    // percent stalls a quiet run anywhere near this limit is very unlikely,
    // so this limit leaves a wide margin.
    localparam int unsigned QUIET_LIMIT   = 5000;
    // The settle wait covers any work still in flight before a register write.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned SEGMENTS      = 10;
    localparam int unsigned SEGMENT_BYTES = 100;

    localparam logic [sbh_pkg::BYTE_W-1:0]    KEY_END   = 8'h00;
    // Register indexes that the block does not decode.
    localparam logic [sbh_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [sbh_pkg::CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

    typedef enum logic {
        ROW_BYTE,
        ROW_REG
    } row_kind_t;

    // One row of the directed stimulus. Rows that end a key may carry a
    // hand-computed bucket index; all others use the predictor.
    typedef struct packed {
        row_kind_t                       kind;
        logic [sbh_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [sbh_pkg::DIVISOR_W-1:0]   value;
        logic                            fixed;
        logic [sbh_pkg::INDEX_W-1:0]     fixed_index;
    } stim_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [sbh_pkg::BYTE_W-1:0]           s_tdata = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [sbh_pkg::OUT_TDATA_W-1:0]      m_tdata;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [sbh_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [sbh_pkg::DEF_BUCKET_WIDTH-1:0] cfg_data = '0;

    // Predictor state: running accumulator and the register copies.
    logic [sbh_pkg::HASH_W-1:0]           hash_acc;
    logic [sbh_pkg::DEF_BUCKET_WIDTH-1:0] bucket_count_reg;
    logic                                 fold_on;

    // Bucket indexes still owed by the block, oldest first.
    logic [sbh_pkg::INDEX_W-1:0]          bucket_q[$];
    stim_row_t                            stim_rows[$];

    int unsigned                tx_gap_pct   = 23;
    int unsigned                rx_stall_pct = 88;
    int unsigned                quiet_cycles = 0;
    int unsigned                errors       = 0;

    string_bucket_hash DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Case folding only touches the 26 upper case ASCII letters.
    function automatic logic [sbh_pkg::BYTE_W-1:0] lowered(
        input logic [sbh_pkg::BYTE_W-1:0] b);
        if (fold_on && b >= sbh_pkg::ASCII_UPPER_A && b <= sbh_pkg::ASCII_UPPER_Z)
        begin
            return b + sbh_pkg::ASCII_CASE_OFFSET;
        end
        return b;
    endfunction

    // Scramble the finished hash and reduce it to a bucket. A count of zero
    // means two buckets, and counts past 2^20 are clamped to 2^20.
    function automatic logic [sbh_pkg::INDEX_W-1:0] bucket_of(
        input logic [sbh_pkg::HASH_W-1:0] acc);
        logic [sbh_pkg::HASH_W-1:0] scrambled;
        logic [sbh_pkg::HASH_W-1:0] buckets;
        scrambled = acc * sbh_pkg::HASH_W'(sbh_pkg::HASH_MULT);
        if (bucket_count_reg == '0)
        begin
            buckets = sbh_pkg::HASH_W'(sbh_pkg::ZERO_COUNT_SUBST);
        end
        else if (bucket_count_reg > sbh_pkg::MAX_BUCKETS)
        begin
            buckets = sbh_pkg::HASH_W'(sbh_pkg::MAX_BUCKETS);
        end
        else
        begin
            buckets = sbh_pkg::HASH_W'(bucket_count_reg);
        end
        return sbh_pkg::INDEX_W'(scrambled % buckets);
    endfunction

    function automatic logic [sbh_pkg::DEF_BUCKET_WIDTH-1:0] random_bucket_count();
        case ($urandom_range(7))
            0: return '0;
            1: return 21'd1;
            2: return 21'($urandom_range(2, 16));
            3: return 21'($urandom_range(17, 4096));
            4: return 21'($urandom);
            5: return sbh_pkg::MAX_BUCKETS;
            6: return sbh_pkg::MAX_BUCKETS - 21'd1;
            default: return 21'h1FFFFF;
        endcase
    endfunction

    // Nonzero key bytes, weighted toward letters so folding gets exercised.
    function automatic logic [sbh_pkg::BYTE_W-1:0] random_key_byte();
        case ($urandom_range(3))
            0: return 8'($urandom_range(sbh_pkg::ASCII_UPPER_A, sbh_pkg::ASCII_UPPER_Z));
            1: return 8'($urandom_range(8'h61, 8'h7A));
            2: return 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // Offer one key byte after a random gap and advance the predictor once
    // the block takes it. A terminator queues the bucket index it owes.
    task automatic push_key_byte(input logic [sbh_pkg::BYTE_W-1:0] b, input logic fixed,
                                 input logic [sbh_pkg::INDEX_W-1:0] fixed_index);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (b == KEY_END)
        begin
            bucket_q.push_back(fixed ? fixed_index : bucket_of(hash_acc));
            hash_acc = '0;
        end
        else
        begin
            hash_acc = hash_acc + (hash_acc << sbh_pkg::HASH_SHIFT) +
                       sbh_pkg::HASH_W'(lowered(b));
        end
    endtask

    // The caller has brought the block to rest first. Valid is left high so
    // that a second write can follow in the next cycle.
    task automatic write_reg(input logic [sbh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sbh_pkg::DEF_BUCKET_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == sbh_pkg::REG_BUCKET_COUNT)
        begin
            bucket_count_reg = val;
        end
        else if (idx == sbh_pkg::REG_CASE_FOLD)
        begin
            fold_on = val[0];
        end
    endtask

    // Stop offering, wait for every owed index, then let the divider settle.
    task automatic drain();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (bucket_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input row_kind_t kind, input logic [sbh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbh_pkg::DIVISOR_W-1:0] val, input logic fixed,
                           input logic [sbh_pkg::INDEX_W-1:0] fixed_index);
        stim_row_t row;
        row.kind        = kind;
        row.reg_idx     = idx;
        row.value       = val;
        row.fixed       = fixed;
        row.fixed_index = fixed_index;
        stim_rows.push_back(row);
    endtask

    // Consumer side: check each accepted index against the oldest one owed,
    // then pick the ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bucket_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected bucket index: expected none, actual %0d",
                         $time, m_tdata[sbh_pkg::INDEX_W-1:0]);
            end
            else if (m_tdata !== sbh_pkg::OUT_TDATA_W'(bucket_q[0]))
            begin
                errors++;
                $display("%0t: bucket index mismatch: expected %0d, actual %0d (tdata %h)",
                         $time, bucket_q[0], m_tdata[sbh_pkg::INDEX_W-1:0], m_tdata);
                void'(bucket_q.pop_front());
            end
            else
            begin
                void'(bucket_q.pop_front());
            end
        end
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("string_bucket_hash_tb: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned key_len;

        hash_acc         = '0;
        bucket_count_reg = sbh_pkg::DEF_BUCKET_WIDTH'(sbh_pkg::ZERO_COUNT_SUBST);
        fold_on          = 1'b0;

        // Directed part. An empty key lands in bucket zero, a one-byte key of
        // 0x01 scrambles to an odd value and so lands in bucket one of two.
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b1, 20'd0);
        add_row(ROW_BYTE, '0, 21'h01, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b1, 20'd1);
        // High bytes are hashed as they are, here with folding off.
        add_row(ROW_BYTE, '0, 21'hFF, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h80, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h7F, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b0, '0);
        add_row(ROW_REG, sbh_pkg::REG_BUCKET_COUNT, 21'd1000, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h41, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h5A, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b0, '0);
        // Folding on: the letter range edges and their neighbors.
        add_row(ROW_REG, sbh_pkg::REG_CASE_FOLD, 21'd1, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h41, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h5A, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h40, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h5B, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b0, '0);
        // A zero count behaves as two buckets.
        add_row(ROW_REG, sbh_pkg::REG_BUCKET_COUNT, 21'd0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h01, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b1, 20'd1);
        // One bucket: everything maps to zero.
        add_row(ROW_REG, sbh_pkg::REG_BUCKET_COUNT, 21'd1, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h55, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b1, 20'd0);
        // All-ones count is clamped; writes to undecoded indexes change nothing.
        add_row(ROW_REG, sbh_pkg::REG_BUCKET_COUNT, 21'h1FFFFF, 1'b0, '0);
        add_row(ROW_REG, REG_TOP, 21'd0, 1'b0, '0);
        add_row(ROW_REG, REG_SPARE, 21'h1FFFFF, 1'b0, '0);
        for (int i = 0; i < 5; i++)
        begin
            add_row(ROW_BYTE, '0, 21'hFF, 1'b0, '0);
        end
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b0, '0);
        add_row(ROW_REG, sbh_pkg::REG_BUCKET_COUNT, 21'(sbh_pkg::MAX_BUCKETS), 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'h7A, 1'b0, '0);
        add_row(ROW_BYTE, '0, 21'(KEY_END), 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_REG)
            begin
                drain();
                write_reg(stim_rows[i].reg_idx, stim_rows[i].value);
            end
            else
            begin
                push_key_byte(sbh_pkg::BYTE_W'(stim_rows[i].value), stim_rows[i].fixed,
                              stim_rows[i].fixed_index);
            end
        end

        // Random part: whole keys with random content and length, a new
        // configuration per segment. The drain before each segment also
        // makes the sender hold off until every owed index has arrived.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 4)
            begin
                tx_gap_pct   = 23;
                rx_stall_pct = 88;
            end
            else if (seg < 7)
            begin
                tx_gap_pct   = 88;
                rx_stall_pct = 23;
            end
            else
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            drain();
            write_reg(sbh_pkg::REG_BUCKET_COUNT, random_bucket_count());
            write_reg(sbh_pkg::REG_CASE_FOLD,
                      sbh_pkg::DEF_BUCKET_WIDTH'($urandom_range(1)));
            if ($urandom_range(3) == 0)
            begin
                write_reg(($urandom_range(1) == 0) ? REG_SPARE : REG_TOP,
                          sbh_pkg::DEF_BUCKET_WIDTH'($urandom));
            end
            sent = 0;
            while (sent < SEGMENT_BYTES)
            begin
                // Mostly short keys; now and then a long one that wraps the
                // accumulator many times over.
                key_len = ($urandom_range(9) == 0) ? $urandom_range(11, 40)
                                                   : $urandom_range(0, 10);
                for (int k = 0; k < key_len; k++)
                begin
                    push_key_byte(random_key_byte(), 1'b0, '0);
                end
                push_key_byte(KEY_END, 1'b0, '0);
                sent += key_len + 1;
            end
        end

        drain();
        if (errors == 0)
        begin
            $display("string_bucket_hash_tb: PASS");
        end
        else
        begin
            $display("string_bucket_hash_tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sbh_pkg.sv
rtl/sbh_div.sv
rtl/string_bucket_hash.sv
dv/string_bucket_hash_tb.sv
